@@ sv/rbac_mls_access_check_core_defines.svh @@
// assertion macros for the access check core
`ifndef RBAC_MLS_ACCESS_CHECK_CORE_DEFINES_SVH
`define RBAC_MLS_ACCESS_CHECK_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, disabled while in reset
`define RMC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("rbac_mls access check assertion failed");
// next-cycle implication, disabled while in reset
`define RMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("rbac_mls access check assertion failed");
`else
`define RMC_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define RMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ sv/rbac_mls_pkg.sv @@
// types, codes and sizes shared by the access check core
package rbac_mls_pkg;

	localparam int SUBJECT_COUNT  = 16;
	localparam int RESOURCE_COUNT = 64;

	localparam logic [4:0] P_R = 5'd1;
	localparam logic [4:0] P_W = 5'd2;
	localparam logic [4:0] P_X = 5'd4;
	localparam logic [4:0] P_D = 5'd8;
	localparam logic [4:0] P_A = 5'd16;

	// rights granted to the owner of a resource
	localparam logic [4:0] OWNER_RIGHTS = P_R | P_W | P_X | P_D;

	typedef enum logic [1:0] {
		CMD_CHECK         = 2'd0,
		CMD_LOAD_SUBJECT  = 2'd1,
		CMD_LOAD_RESOURCE = 2'd2,
		CMD_UNUSED        = 2'd3
	} command_t;

	typedef enum logic [2:0] {
		DENY_NONE       = 3'd0,
		DENY_NOT_FOUND  = 3'd1,
		DENY_READ_UP    = 3'd2,
		DENY_WRITE_DOWN = 3'd3,
		DENY_RIGHTS     = 3'd4
	} deny_reason_t;

	typedef struct packed {
		command_t   command;
		logic [3:0] subject_id;
		logic [5:0] resource_id;
		logic [4:0] request_perms;
		logic [3:0] role_mask;
		logic [1:0] clearance_level;
		logic [3:0] owner_id;
		logic [1:0] resource_label;
		logic [4:0] acl_admin;
		logic [4:0] acl_manager;
		logic [4:0] acl_analyst;
		logic [4:0] acl_user;
	} item_t;

	typedef struct packed {
		logic         allowed;
		deny_reason_t deny_reason;
	} result_t;

	// one subject table entry
	typedef struct packed {
		logic [3:0] roles;
		logic [1:0] clearance;
	} subject_entry_t;

	// one resource table entry, rights: admin 4..0, manager 9..5,
	// analyst 14..10, user 19..15
	typedef struct packed {
		logic [3:0]  owner;
		logic [1:0]  level;
		logic [19:0] rights;
	} resource_entry_t;

	// role set after expansion through admin > manager > analyst > user
	function automatic logic [3:0] expand_roles(input logic [3:0] m);
		logic adm;
		logic mgr;
		logic ana;
		logic usr;
		adm = m[0];
		mgr = adm | m[1];
		ana = mgr | m[2];
		usr = ana | m[3];
		return {usr, ana, mgr, adm};
	endfunction

endpackage

@@ sv/rbac_mls_access_check_core.sv @@
// role based access checker with multi level security rules
// order: a check transaction accepted registers into stage 1, then into the result
//   register, which drives its result strobe; loads and the unused command give no result
// throughput: one transaction per cycle, busy is always low, the receiver cannot stall
// reset: the presence bits and the pipeline valids clear at once, table contents
//   are undefined until loaded
module rbac_mls_access_check_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  rbac_mls_pkg::item_t   item,
	output logic                  valid,
	output rbac_mls_pkg::result_t result
);
	import rbac_mls_pkg::*;

	`include "rbac_mls_access_check_core_defines.svh"

	// ---------------------------------------------------------------
	// accept: the core never stalls, a transaction can enter every cycle
	// ---------------------------------------------------------------
	logic accept;
	logic is_check;
	logic is_load_sub;
	logic is_load_res;

	assign busy        = 1'b0;
	assign accept      = start & ~busy;
	assign is_check    = accept & (item.command == CMD_CHECK);
	assign is_load_sub = accept & (item.command == CMD_LOAD_SUBJECT);
	assign is_load_res = accept & (item.command == CMD_LOAD_RESOURCE);

	// ---------------------------------------------------------------
	// tables: presence bits in flops, entry contents in memories with
	// registered read; a load writes on its accept edge, a check reads
	// on its own edge, so a check right after a load already sees it
	// ---------------------------------------------------------------
	logic [SUBJECT_COUNT-1:0]  sub_present_q;
	logic [RESOURCE_COUNT-1:0] res_present_q;

	subject_entry_t  sub_mem [SUBJECT_COUNT];
	resource_entry_t res_mem [RESOURCE_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_present_q <= '0;
			res_present_q <= '0;
		end else begin
			if (is_load_sub) begin
				sub_present_q[item.subject_id] <= 1'b1;
			end
			if (is_load_res) begin
				res_present_q[item.resource_id] <= 1'b1;
			end
		end
	end

	// stage 1 registers: the check transaction and its table reads
	logic            check_s1;
	logic            sub_hit_s1;
	logic            res_hit_s1;
	logic [3:0]      sid_s1;
	logic [4:0]      perms_s1;
	subject_entry_t  sub_rd_s1;
	resource_entry_t res_rd_s1;

	always_ff @(posedge clk) begin
		if (is_load_sub) begin
			sub_mem[item.subject_id] <= '{roles: item.role_mask,
				clearance: item.clearance_level};
		end
		sub_rd_s1 <= sub_mem[item.subject_id];
	end

	always_ff @(posedge clk) begin
		if (is_load_res) begin
			res_mem[item.resource_id] <= '{owner: item.owner_id,
				level: item.resource_label,
				rights: {item.acl_user, item.acl_analyst,
					item.acl_manager, item.acl_admin}};
		end
		res_rd_s1 <= res_mem[item.resource_id];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_s1 <= 1'b0;
		end else begin
			check_s1 <= is_check;
		end
	end

	// payload and presence snapshot, no reset needed
	always_ff @(posedge clk) begin
		sid_s1     <= item.subject_id;
		perms_s1   <= item.request_perms;
		sub_hit_s1 <= sub_present_q[item.subject_id];
		res_hit_s1 <= res_present_q[item.resource_id];
	end

	// ---------------------------------------------------------------
	// decision logic between stage 1 and the result register
	// ---------------------------------------------------------------
	logic [3:0]   roles_x;
	logic [4:0]   eff_rights;
	logic         read_up;
	logic         write_down;
	result_t      result_d;

	always_comb begin
		roles_x    = expand_roles(sub_rd_s1.roles);
		eff_rights = (res_rd_s1.owner == sid_s1) ? OWNER_RIGHTS : 5'd0;
		for (int k = 0; k < 4; k++) begin
			if (roles_x[k]) begin
				eff_rights = eff_rights | res_rd_s1.rights[5*k +: 5];
			end
		end

		// no reading above the clearance, no writing below it
		read_up    = ((perms_s1 & P_R) != 5'd0) && (sub_rd_s1.clearance < res_rd_s1.level);
		write_down = ((perms_s1 & P_W) != 5'd0) && (sub_rd_s1.clearance > res_rd_s1.level);

		if (!sub_hit_s1 || !res_hit_s1) begin
			result_d = '{allowed: 1'b0, deny_reason: DENY_NOT_FOUND};
		end else if (read_up) begin
			result_d = '{allowed: 1'b0, deny_reason: DENY_READ_UP};
		end else if (write_down) begin
			result_d = '{allowed: 1'b0, deny_reason: DENY_WRITE_DOWN};
		end else if ((eff_rights & perms_s1) == perms_s1) begin
			result_d = '{allowed: 1'b1, deny_reason: DENY_NONE};
		end else begin
			result_d = '{allowed: 1'b0, deny_reason: DENY_RIGHTS};
		end
	end

	// ---------------------------------------------------------------
	// result register: strobe is high for one cycle per check
	// ---------------------------------------------------------------
	logic    valid_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= check_s1;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	assign valid  = valid_q;
	assign result = result_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	`RMC_ASSERT_NEXT(a_check_reaches_s1, clk, arst_n, is_check, check_s1)
	`RMC_ASSERT_NEXT(a_load_gives_no_result, clk, arst_n, accept && !is_check, !check_s1)
	`RMC_ASSERT_SAME(a_allow_has_no_reason, clk, arst_n, valid_q, (result_q.allowed == (result_q.deny_reason == DENY_NONE)))
	`RMC_ASSERT_SAME(a_valid_from_s1, clk, arst_n, valid_q, $past(check_s1))

endmodule

@@ verif/access_verdict_checker.sv @@
// checker that predicts and compares access check verdicts for the core
`timescale 1ns / 100ps

module access_verdict_checker
	import rbac_mls_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  item_t   item,
	input  logic    valid,
	input  result_t result,
	output int      fail_count,
	output int      pending,
	output int      verdict_count,
	output logic [4:0] reasons_seen
);

	logic            subj_loaded [SUBJECT_COUNT];
	subject_entry_t  subj_tab    [SUBJECT_COUNT];
	logic            res_loaded  [RESOURCE_COUNT];
	resource_entry_t res_tab     [RESOURCE_COUNT];

	result_t verdict_q [$];
	result_t want;

	// verdict for one check against the current tables
	function automatic result_t judge_access(input item_t it);
		result_t         v;
		subject_entry_t  s;
		resource_entry_t r;
		logic [4:0]      eff;
		logic            held;
		v.allowed = 1'b0;
		if (!subj_loaded[it.subject_id] || !res_loaded[it.resource_id]) begin
			v.deny_reason = DENY_NOT_FOUND;
			return v;
		end
		s = subj_tab[it.subject_id];
		r = res_tab[it.resource_id];
		if ((it.request_perms & P_R) != 0 && s.clearance < r.level) begin
			v.deny_reason = DENY_READ_UP;
			return v;
		end
		if ((it.request_perms & P_W) != 0 && s.clearance > r.level) begin
			v.deny_reason = DENY_WRITE_DOWN;
			return v;
		end
		eff = (r.owner == it.subject_id) ? (P_R | P_W | P_X | P_D) : 5'd0;
		// a higher role implies every lower one
		held = 1'b0;
		for (int k = 0; k < 4; k++) begin
			held = held | s.roles[k];
			if (held)
				eff = eff | r.rights[5*k +: 5];
		end
		if ((eff & it.request_perms) == it.request_perms) begin
			v.allowed     = 1'b1;
			v.deny_reason = DENY_NONE;
		end else begin
			v.deny_reason = DENY_RIGHTS;
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SUBJECT_COUNT; i++)
				subj_loaded[i] = 1'b0;
			for (int i = 0; i < RESOURCE_COUNT; i++)
				res_loaded[i] = 1'b0;
			verdict_q.delete();
			fail_count    = 0;
			pending       = 0;
			verdict_count = 0;
			reasons_seen  = '0;
		end else begin
			// results first: they belong to transactions taken on earlier edges
			if (valid) begin
				verdict_count++;
				if (verdict_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, actual allowed %0d reason %0d",
						$time, result.allowed, result.deny_reason);
				end else begin
					want = verdict_q.pop_front();
					if (result.deny_reason <= DENY_RIGHTS)
						reasons_seen[result.deny_reason] = 1'b1;
					if (result.allowed !== want.allowed) begin
						fail_count++;
						$display("%0t: allowed mismatch, expected %0d actual %0d",
							$time, want.allowed, result.allowed);
					end
					if (result.deny_reason !== want.deny_reason) begin
						fail_count++;
						$display("%0t: deny reason mismatch, expected %0d actual %0d",
							$time, want.deny_reason, result.deny_reason);
					end
				end
			end
			if (start && !busy) begin
				case (item.command)
					CMD_CHECK: verdict_q = {verdict_q, judge_access(item)};
					CMD_LOAD_SUBJECT: begin
						subj_loaded[item.subject_id] = 1'b1;
						subj_tab[item.subject_id].roles     = item.role_mask;
						subj_tab[item.subject_id].clearance = item.clearance_level;
					end
					CMD_LOAD_RESOURCE: begin
						res_loaded[item.resource_id] = 1'b1;
						res_tab[item.resource_id].owner  = item.owner_id;
						res_tab[item.resource_id].level  = item.resource_label;
						res_tab[item.resource_id].rights = {item.acl_user, item.acl_analyst,
							item.acl_manager, item.acl_admin};
					end
					default: ;
				endcase
			end
			pending = verdict_q.size();
		end
	end

endmodule

@@ verif/tb_top.sv @@
// testbench top: stimulus, watchdog and verdict for the access check core
`timescale 1ns / 100ps

module tb_top;
	import rbac_mls_pkg::*;

	localparam int RANDOM_ITEMS = 1200;
	localparam int CALM_TAIL    = 200;   // last stretch runs with no gaps
	localparam int STALL_LIMIT  = 500;   // cycles with no transaction or result before giving up

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    valid;
	result_t result;

	int         fail_count;
	int         pending;
	int         verdict_count;
	logic [4:0] reasons_seen;

	int sent_count;
	int quiet_cycles;

	// ids loaded so far, used to aim checks at populated entries
	bit subj_seen [SUBJECT_COUNT];
	bit res_seen  [RESOURCE_COUNT];
	int subj_ids  [$];
	int res_ids   [$];

	rbac_mls_access_check_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.valid  (valid),
		.result (result)
	);

	access_verdict_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.valid         (valid),
		.result        (result),
		.fail_count    (fail_count),
		.pending       (pending),
		.verdict_count (verdict_count),
		.reasons_seen  (reasons_seen)
	);

	// 10 ns clock
	initial
		clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: the run must keep moving transactions or results
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || valid) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	// every field random, so unused fields toggle too
	function automatic item_t noise_item();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return raw[$bits(item_t)-1:0];
	endfunction

	function automatic item_t check_of(input int sid, input int rid, input logic [4:0] req);
		item_t it;
		it               = noise_item();
		it.command       = CMD_CHECK;
		it.subject_id    = 4'(sid);
		it.resource_id   = 6'(rid);
		it.request_perms = req;
		return it;
	endfunction

	function automatic item_t subject_of(input int sid, input logic [3:0] roles,
		input logic [1:0] clr);
		item_t it;
		it                 = noise_item();
		it.command         = CMD_LOAD_SUBJECT;
		it.subject_id      = 4'(sid);
		it.role_mask       = roles;
		it.clearance_level = clr;
		return it;
	endfunction

	function automatic item_t resource_of(input int rid, input int owner, input logic [1:0] lvl,
		input logic [4:0] adm, input logic [4:0] mgr, input logic [4:0] ana,
		input logic [4:0] usr);
		item_t it;
		it                = noise_item();
		it.command        = CMD_LOAD_RESOURCE;
		it.resource_id    = 6'(rid);
		it.owner_id       = 4'(owner);
		it.resource_label = lvl;
		it.acl_admin      = adm;
		it.acl_manager    = mgr;
		it.acl_analyst    = ana;
		it.acl_user       = usr;
		return it;
	endfunction

	// drive one transaction at the falling edge and hold it until taken
	task automatic send(input item_t it);
		item  <= it;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		sent_count++;
		if (it.command == CMD_LOAD_SUBJECT && !subj_seen[it.subject_id]) begin
			subj_seen[it.subject_id] = 1'b1;
			subj_ids = {subj_ids, int'(it.subject_id)};
		end
		if (it.command == CMD_LOAD_RESOURCE && !res_seen[it.resource_id]) begin
			res_seen[it.resource_id] = 1'b1;
			res_ids = {res_ids, int'(it.resource_id)};
		end
		@(negedge clk);
	endtask

	// idle burst, with junk on the item bus while start is low
	task automatic rest(input int cycles);
		start <= 1'b0;
		item  <= noise_item();
		repeat (cycles) @(negedge clk);
	endtask

	initial begin
		item_t it;
		int    pick;
		bit    gappy;

		arst_n     = 1'b0;
		start      = 1'b0;
		item       = '0;
		sent_count = 0;
		gappy      = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part
		send(check_of(0, 0, P_R));                      // both tables empty: not found
		send(subject_of(0, 4'b0000, 2'd0));
		send(subject_of(15, 4'b1111, 2'd3));
		send(subject_of(5, 4'b1000, 2'd2));             // user only
		send(subject_of(6, 4'b0001, 2'd1));             // admin only
		send(resource_of(0, 0, 2'd0, 5'd0, 5'd0, 5'd0, 5'd0));
		send(resource_of(63, 15, 2'd3, 5'd31, 5'd31, 5'd31, 5'd31));
		send(resource_of(10, 3, 2'd2, P_A, P_X, P_D, P_R));
		rest(3);
		send(check_of(0, 63, P_R));                     // read up
		send(check_of(15, 0, P_W));                     // write down
		send(check_of(15, 63, 5'd31));                  // full request, admin grants all
		send(check_of(0, 0, 5'd0));                     // empty request
		send(check_of(0, 0, P_X));                      // owner rights
		send(check_of(0, 0, P_A));                      // owner never gets a
		send(check_of(5, 10, P_R));                     // user role grants r
		send(check_of(5, 10, P_X));                     // lacking rights
		send(check_of(6, 10, P_A | P_X | P_D));         // admin pulls in lower masks
		send(check_of(6, 10, P_R));                     // read up from admin too
		it         = noise_item();
		it.command = CMD_UNUSED;
		send(it);                                       // ignored, no result
		send(check_of(1, 0, P_R));                      // subject missing
		send(check_of(0, 1, 5'd0));                     // resource missing
		send(subject_of(0, 4'b0000, 2'd3));             // reload with new clearance
		send(check_of(0, 0, P_W));                      // now a write down
		send(resource_of(20, 7, 2'd1, 5'd0, 5'd0, 5'd0, 5'd0));
		send(subject_of(7, 4'b0000, 2'd1));             // owner loaded after the resource
		send(check_of(7, 20, P_R | P_W | P_X | P_D));

		// random part: mostly checks aimed at loaded entries
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				gappy = ($urandom_range(0, 3) != 0);
			if (n >= RANDOM_ITEMS - CALM_TAIL)
				gappy = 1'b0;
			it   = noise_item();
			pick = $urandom_range(0, 99);
			if (pick < 14)
				it.command = CMD_LOAD_SUBJECT;
			else if (pick < 32)
				it.command = CMD_LOAD_RESOURCE;
			else if (pick < 96)
				it.command = CMD_CHECK;
			else
				it.command = CMD_UNUSED;
			if (it.command == CMD_CHECK) begin
				if ($urandom_range(0, 99) < 85 && subj_ids.size() != 0)
					it.subject_id = 4'(subj_ids[$urandom_range(0, subj_ids.size() - 1)]);
				if ($urandom_range(0, 99) < 85 && res_ids.size() != 0)
					it.resource_id = 6'(res_ids[$urandom_range(0, res_ids.size() - 1)]);
				// single rights and the empty request show up more often
				if ($urandom_range(0, 3) == 0)
					it.request_perms = 5'd1 << $urandom_range(0, 4);
				else if ($urandom_range(0, 15) == 0)
					it.request_perms = 5'd0;
			end
			send(it);
			if (gappy && $urandom_range(0, 2) == 0)
				rest($urandom_range(1, 9));
		end
		start <= 1'b0;

		// drain: wait until no predicted verdict is still pending
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("run covered %0d transactions and %0d checked verdicts",
			sent_count, verdict_count);
		$display("deny reasons observed, one bit per code from allow upward: %b",
			reasons_seen);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("FAIL");
		end
		$finish;
	end

endmodule
